// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

    localparam int ID_W       = 8;
    localparam int TYPE_W     = 8;
    localparam int SIZE_W     = 16;
    localparam int AREA_IDX_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_AREAS  = 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MANAGER_ID = 3'd0;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    localparam logic [TYPE_W-1:0] EMPTY_TYPE = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_MEMBER,
        ST_REMOVE,
        ST_LOOKUP,
        ST_DONE
    } state_t;

    // Results of the shared compare unit for the table entry under the scan index.
    typedef struct packed {
        logic owner_eq;
        logic member_eq;
        logic member_empty;
        logic fits;
        logic better;
    } cmp_res_t;

endpackage

// ===== rtl/bfa_cmp_unit.sv =====
module bfa_cmp_unit (
    input  logic [bfa_pkg::ID_W-1:0]   client_id,
    input  logic [bfa_pkg::ID_W-1:0]   owner,
    input  logic [bfa_pkg::ID_W-1:0]   member,
    input  logic                       area_usable,
    input  logic [bfa_pkg::SIZE_W-1:0] area_size,
    input  logic [bfa_pkg::SIZE_W-1:0] needed_size,
    input  logic [bfa_pkg::SIZE_W-1:0] best_size,
    input  logic                       have_best,
    output bfa_pkg::cmp_res_t          res
);
    import bfa_pkg::*;

    always_comb begin
        res.owner_eq     = (owner == client_id);
        res.member_eq    = (member == client_id);
        res.member_empty = (member == '0);
        // A free area that is big enough; on equal sizes the earlier index stays.
        res.fits         = area_usable && (owner == '0) && (area_size >= needed_size);
        res.better       = !have_best || (best_size > area_size);
    end

endmodule

// ===== rtl/best_fit_area_allocator.sv =====
// Best-fit message area allocator with a member table.
// Input channel (s_*): one word carries an operation (add, remove, lookup), an
// agent id, an agent type and a needed size. Result channel (m_*): one word per
// input word with status, area index and found flag.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 manager id,
// 1 to 7 area sizes). Write only while no word is in flight.
// Sequencing: an add makes one pass over the area table, then a member pass
// that stops at the first empty slot; id zero, a duplicate id or no fitting
// area ends after the area pass. Remove makes one full pass and lookup stops
// at the first owned area, one table entry per cycle through the shared
// compare unit. The result becomes valid in the same cycle as the sequencer
// is ready again.
// s_ready is high only while the sequencer is idle, so one word is worked on at
// a time. A finished result sits in the output register; the next input word
// is taken while it waits, and the sequencer holds its own result until the
// output register is free. With m_ready held low the block stops after that.
// Reset frees all areas, empties the member table, sets the manager id to 1
// and all area sizes to 0.
module best_fit_area_allocator #(
    parameter int NUM_AREAS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfa_pkg::SIZE_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [bfa_pkg::ID_W-1:0]      s_client_id,
    input  logic [bfa_pkg::TYPE_W-1:0]    s_agent_type,
    input  logic [bfa_pkg::SIZE_W-1:0]    s_needed_size,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic [bfa_pkg::AREA_IDX_W-1:0] m_area_index,
    output logic                          m_found
);
    import bfa_pkg::*;

    localparam int IDX_W = $clog2(NUM_AREAS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_AREAS - 1);

    state_t state_reg, state_next;

    logic [ID_W-1:0]   manager_id_reg;
    logic [SIZE_W-1:0] area_size_reg [MAX_AREAS];
    logic [ID_W-1:0]   area_owner_reg [NUM_AREAS];
    logic [ID_W-1:0]   member_id_reg [NUM_AREAS];
    logic [TYPE_W-1:0] member_type_reg [NUM_AREAS];

    logic [1:0]        op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [SIZE_W-1:0] need_reg;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              dup_reg, dup_next;
    logic              have_reg, have_next;
    logic [IDX_W-1:0]  best_reg, best_next;
    logic [SIZE_W-1:0] best_size_reg, best_size_next;

    logic                  res_status_reg, res_status_next;
    logic [AREA_IDX_W-1:0] res_index_reg, res_index_next;
    logic                  res_found_reg, res_found_next;

    logic                  m_valid_reg;
    logic                  m_status_reg;
    logic [AREA_IDX_W-1:0] m_area_index_reg;
    logic                  m_found_reg;

    logic accept;
    logic last;
    logic out_free;
    logic load_out;
    logic [ID_W-1:0]   owner_rd;
    logic [SIZE_W-1:0] size_rd;
    cmp_res_t          cmp;

    logic owner_claim;
    logic owner_clear;
    logic member_fill;
    logic member_clear;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign last     = (idx_reg == LAST_IDX);
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_DONE) && out_free;

    assign owner_rd = (idx_reg == '0) ? manager_id_reg : area_owner_reg[idx_reg];
    assign size_rd  = area_size_reg[AREA_IDX_W'(idx_reg)];

    bfa_cmp_unit u_cmp (
        .client_id   (id_reg),
        .owner       (owner_rd),
        .member      (member_id_reg[idx_reg]),
        .area_usable (idx_reg != '0),
        .area_size   (size_rd),
        .needed_size (need_reg),
        .best_size   (best_size_reg),
        .have_best   (have_reg),
        .res         (cmp)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_operation)
                        OP_ADD:    state_next = ST_AREA;
                        OP_REMOVE: state_next = ST_REMOVE;
                        OP_LOOKUP: state_next = ST_LOOKUP;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_AREA: begin
                if (last) begin
                    state_next = (dup_next || !have_next) ? ST_DONE : ST_MEMBER;
                end
            end
            ST_MEMBER: begin
                if (cmp.member_empty || last) begin
                    state_next = ST_DONE;
                end
            end
            ST_REMOVE: begin
                if (last) begin
                    state_next = ST_DONE;
                end
            end
            ST_LOOKUP: begin
                if ((cmp.owner_eq && id_reg != '0) || last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Scan bookkeeping, table write enables and the pending result.
    always_comb begin
        idx_next        = idx_reg + IDX_W'(1);
        dup_next        = dup_reg;
        have_next       = have_reg;
        best_next       = best_reg;
        best_size_next  = best_size_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_found_next  = res_found_reg;
        owner_claim     = 1'b0;
        owner_clear     = 1'b0;
        member_fill     = 1'b0;
        member_clear    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                idx_next        = '0;
                dup_next        = (s_client_id == '0);
                have_next       = 1'b0;
                res_status_next = STATUS_FAIL;
                res_index_next  = '0;
                res_found_next  = 1'b0;
            end
            ST_AREA: begin
                if (cmp.owner_eq && id_reg != '0) begin
                    dup_next = 1'b1;
                end
                if (cmp.fits && cmp.better) begin
                    have_next      = 1'b1;
                    best_next      = idx_reg;
                    best_size_next = size_rd;
                end
                if (last) begin
                    idx_next = '0;
                end
            end
            ST_MEMBER: begin
                // The chosen area is claimed on the first member cycle.
                owner_claim     = (idx_reg == '0);
                res_index_next  = AREA_IDX_W'(best_reg);
                res_found_next  = 1'b1;
                if (cmp.member_empty) begin
                    member_fill     = 1'b1;
                    res_status_next = STATUS_OK;
                end else begin
                    res_status_next = STATUS_FAIL;
                end
            end
            ST_REMOVE: begin
                owner_clear     = cmp.owner_eq && (idx_reg != '0);
                member_clear    = cmp.member_eq;
                res_status_next = STATUS_OK;
            end
            ST_LOOKUP: begin
                if (cmp.owner_eq && id_reg != '0) begin
                    res_status_next = STATUS_OK;
                    res_index_next  = AREA_IDX_W'(idx_reg);
                    res_found_next  = 1'b1;
                end
            end
            ST_DONE: begin
                idx_next = idx_reg;
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            manager_id_reg <= ID_W'(1);
            for (int i = 0; i < MAX_AREAS; i++) begin
                area_size_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_AREAS; i++) begin
                area_owner_reg[i]  <= '0;
                member_id_reg[i]   <= '0;
                member_type_reg[i] <= EMPTY_TYPE;
            end
        end else begin
            state_reg <= state_next;

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_we) begin
                if (cfg_index == CFG_MANAGER_ID) begin
                    manager_id_reg <= cfg_wdata[ID_W-1:0];
                end else begin
                    area_size_reg[cfg_index] <= cfg_wdata;
                end
            end

            if (owner_claim) begin
                area_owner_reg[best_reg] <= id_reg;
            end else if (owner_clear) begin
                area_owner_reg[idx_reg] <= '0;
            end

            if (member_fill) begin
                member_id_reg[idx_reg]   <= id_reg;
                member_type_reg[idx_reg] <= type_reg;
            end else if (member_clear) begin
                member_id_reg[idx_reg]   <= '0;
                member_type_reg[idx_reg] <= EMPTY_TYPE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_operation;
            id_reg   <= s_client_id;
            type_reg <= s_agent_type;
            need_reg <= s_needed_size;
        end
        idx_reg        <= idx_next;
        dup_reg        <= dup_next;
        have_reg       <= have_next;
        best_reg       <= best_next;
        best_size_reg  <= best_size_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_found_reg  <= res_found_next;
        if (load_out) begin
            m_status_reg     <= res_status_reg;
            m_area_index_reg <= res_index_reg;
            m_found_reg      <= res_found_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_area_index = m_area_index_reg;
    assign m_found      = m_found_reg;

    // The member pass only runs for a fresh id that found a fitting area.
    a_member_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MEMBER) |-> (have_reg && !dup_reg && op_reg == OP_ADD))
        else $error("member pass entered without a claimable area");

    // Area zero belongs to the manager and is never stored or claimed.
    a_area0_free: assert property (@(posedge aclk) disable iff (!aresetn)
        area_owner_reg[0] == '0)
        else $error("area zero was written");

    // The best area is never area zero.
    a_best_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        have_reg |-> (best_reg != '0))
        else $error("best-fit choice points at area zero");

    // A result without a found area reports index zero.
    a_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_area_index == '0))
        else $error("area index set on a miss");

    // An accepted word always starts the sequencer.
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after accepting a word");

endmodule

// ===== bench/tb.sv =====
module tb;
    import bfa_pkg::*;

    localparam logic [1:0]           OP_UNUSED       = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_SIZE_1 = CFG_MANAGER_ID + 3'd1;
    localparam int SETTLE_CYCLES = 2 * MAX_AREAS + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 8;
    localparam int WORDS_PER_PHASE = 250;
    localparam int LIMIT_CYCLES  = 400000;

    typedef struct packed {
        logic                  status;
        logic [AREA_IDX_W-1:0] area_index;
        logic                  found;
    } area_reply_t;

    typedef enum logic {ROW_REQ, ROW_SET} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  fixed;
        logic [1:0]            op;
        logic [ID_W-1:0]       id;
        logic [TYPE_W-1:0]     atype;
        logic [SIZE_W-1:0]     need;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [SIZE_W-1:0]     reg_val;
        area_reply_t           reply;
    } script_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [SIZE_W-1:0]     cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_operation;
    logic [ID_W-1:0]       s_client_id;
    logic [TYPE_W-1:0]     s_agent_type;
    logic [SIZE_W-1:0]     s_needed_size;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_status;
    logic [AREA_IDX_W-1:0] m_area_index;
    logic                  m_found;

    // Private copy of the allocator tables and registers.
    logic [ID_W-1:0]   mgr_id;
    logic [SIZE_W-1:0] area_cap    [MAX_AREAS];
    logic [ID_W-1:0]   area_holder [MAX_AREAS];
    logic [ID_W-1:0]   slot_id     [MAX_AREAS];
    logic [TYPE_W-1:0] slot_type   [MAX_AREAS];

    area_reply_t pending_replies[$];
    script_row_t script[$];
    int fail_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    logic hold_req = 1'b0;
    int cycle_count;

    best_fit_area_allocator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_client_id   (s_client_id),
        .s_agent_type  (s_agent_type),
        .s_needed_size (s_needed_size),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_area_index  (m_area_index),
        .m_found       (m_found)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [CFG_IDX_W-1:0] cap_reg(int area);
        return CFG_AREA_SIZE_1 + CFG_IDX_W'(area - 1);
    endfunction

    // Area 0 always reads as owned by the manager id; id zero owns nothing.
    function automatic int owned_area(logic [ID_W-1:0] id);
        if (id == '0)
            return -1;
        for (int i = 0; i < MAX_AREAS; i++)
            if (((i == 0) ? mgr_id : area_holder[i]) == id)
                return i;
        return -1;
    endfunction

    function automatic area_reply_t apply_request(logic [1:0] op, logic [ID_W-1:0] id,
                                                  logic [TYPE_W-1:0] atype,
                                                  logic [SIZE_W-1:0] need);
        area_reply_t r;
        int best;
        int hit;
        logic placed;
        r.status     = STATUS_FAIL;
        r.area_index = '0;
        r.found      = 1'b0;
        case (op)
            OP_ADD: begin
                best = -1;
                placed = 1'b0;
                if (id != '0 && owned_area(id) < 0) begin
                    for (int i = 1; i < MAX_AREAS; i++)
                        if (area_holder[i] == '0 && area_cap[i] >= need &&
                            (best < 0 || area_cap[best] > area_cap[i]))
                            best = i;
                    if (best >= 0) begin
                        // The area stays claimed even if no member slot is free.
                        area_holder[best] = id;
                        r.area_index = AREA_IDX_W'(best);
                        r.found = 1'b1;
                        for (int i = 0; i < MAX_AREAS; i++)
                            if (!placed && slot_id[i] == '0) begin
                                slot_id[i] = id;
                                slot_type[i] = atype;
                                placed = 1'b1;
                                r.status = STATUS_OK;
                            end
                    end
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < MAX_AREAS; i++) begin
                    if (i != 0 && area_holder[i] == id)
                        area_holder[i] = '0;
                    if (slot_id[i] == id) begin
                        slot_id[i] = '0;
                        slot_type[i] = EMPTY_TYPE;
                    end
                end
                r.status = STATUS_OK;
            end
            OP_LOOKUP: begin
                hit = owned_area(id);
                if (hit >= 0) begin
                    r.status = STATUS_OK;
                    r.area_index = AREA_IDX_W'(hit);
                    r.found = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic script_row_t req_row(logic [1:0] op, logic [ID_W-1:0] id,
                                            logic [TYPE_W-1:0] atype,
                                            logic [SIZE_W-1:0] need);
        script_row_t row;
        row = '0;
        row.kind = ROW_REQ;
        row.op = op;
        row.id = id;
        row.atype = atype;
        row.need = need;
        return row;
    endfunction

    function automatic script_row_t chk_row(logic [1:0] op, logic [ID_W-1:0] id,
                                            logic [SIZE_W-1:0] need, logic status,
                                            logic [AREA_IDX_W-1:0] idx, logic found);
        script_row_t row;
        row = req_row(op, id, 8'h3C, need);
        row.fixed = 1'b1;
        row.reply.status = status;
        row.reply.area_index = idx;
        row.reply.found = found;
        return row;
    endfunction

    function automatic script_row_t set_row(logic [CFG_IDX_W-1:0] idx,
                                            logic [SIZE_W-1:0] val);
        script_row_t row;
        row = '0;
        row.kind = ROW_SET;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic offer(logic [1:0] op, logic [ID_W-1:0] id, logic [TYPE_W-1:0] atype,
                         logic [SIZE_W-1:0] need, logic fixed, area_reply_t fixed_reply);
        area_reply_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_client_id   <= id;
        s_agent_type  <= atype;
        s_needed_size <= need;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        r = apply_request(op, id, atype, need);
        pending_replies.push_back(fixed ? fixed_reply : r);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == CFG_MANAGER_ID)
            mgr_id = val[ID_W-1:0];
        else
            area_cap[idx] = val;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random stalls, or one long hold-off when requested.
    initial begin : receiver
        int held;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_replies
        area_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected word: status %0d area_index %0d found %0d",
                       m_status, m_area_index, m_found);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    fail_count++;
                end
                if (m_area_index !== want.area_index) begin
                    $error("area_index: expected %0d, got %0d", want.area_index,
                           m_area_index);
                    fail_count++;
                end
                if (m_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_found);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        logic prev_set;
        logic [1:0] op;
        logic [ID_W-1:0] id;
        logic [SIZE_W-1:0] need;
        logic [SIZE_W-1:0] val;
        logic [AREA_IDX_W-1:0] pick;
        int roll;

        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_operation   = OP_ADD;
        s_client_id   = '0;
        s_agent_type  = '0;
        s_needed_size = '0;

        mgr_id = 8'd1;
        for (int i = 0; i < MAX_AREAS; i++) begin
            area_cap[i]    = '0;
            area_holder[i] = '0;
            slot_id[i]     = '0;
            slot_type[i]   = EMPTY_TYPE;
        end

        // Reset values: manager id 1 owns area 0, every capacity is zero.
        script.push_back(chk_row(OP_LOOKUP, 8'd1, 16'd0, STATUS_OK, 3'd0, 1'b1));
        script.push_back(chk_row(OP_ADD, 8'd1, 16'd0, STATUS_FAIL, 3'd0, 1'b0));
        script.push_back(chk_row(OP_ADD, 8'd0, 16'd0, STATUS_FAIL, 3'd0, 1'b0));
        script.push_back(chk_row(OP_ADD, 8'h80, 16'd0, STATUS_OK, 3'd1, 1'b1));
        script.push_back(chk_row(OP_ADD, 8'h81, 16'd1, STATUS_FAIL, 3'd0, 1'b0));
        script.push_back(chk_row(OP_ADD, 8'h80, 16'd0, STATUS_FAIL, 3'd0, 1'b0));
        script.push_back(chk_row(OP_UNUSED, 8'h80, 16'hFFFF, STATUS_FAIL, 3'd0, 1'b0));
        script.push_back(chk_row(OP_LOOKUP, 8'd0, 16'd0, STATUS_FAIL, 3'd0, 1'b0));
        script.push_back(chk_row(OP_REMOVE, 8'd0, 16'd0, STATUS_OK, 3'd0, 1'b0));
        script.push_back(chk_row(OP_LOOKUP, 8'h80, 16'd0, STATUS_OK, 3'd1, 1'b1));
        script.push_back(set_row(CFG_MANAGER_ID, 16'd255));
        script.push_back(set_row(cap_reg(1), 16'hFFFF));
        script.push_back(set_row(cap_reg(2), 16'd100));
        script.push_back(set_row(cap_reg(3), 16'd50));
        script.push_back(set_row(cap_reg(4), 16'd50));
        script.push_back(set_row(cap_reg(5), 16'd0));
        script.push_back(set_row(cap_reg(6), 16'hFFFF));
        script.push_back(set_row(cap_reg(7), 16'd200));
        // Best fit with a tie between areas three and four.
        script.push_back(req_row(OP_ADD, 8'h7F, 8'h55, 16'd50));
        script.push_back(req_row(OP_ADD, 8'h01, 8'hFF, 16'd50));
        script.push_back(req_row(OP_ADD, 8'h02, 8'hAA, 16'hFFFF));
        script.push_back(chk_row(OP_ADD, 8'h03, 16'hFFFF, STATUS_FAIL, 3'd0, 1'b0));
        script.push_back(chk_row(OP_ADD, 8'hFF, 16'd0, STATUS_FAIL, 3'd0, 1'b0));
        // Removing the manager leaves area zero in place.
        script.push_back(chk_row(OP_REMOVE, 8'hFF, 16'd0, STATUS_OK, 3'd0, 1'b0));
        script.push_back(chk_row(OP_LOOKUP, 8'hFF, 16'd0, STATUS_OK, 3'd0, 1'b1));
        script.push_back(chk_row(OP_REMOVE, 8'h80, 16'd0, STATUS_OK, 3'd0, 1'b0));
        script.push_back(chk_row(OP_LOOKUP, 8'h80, 16'd0, STATUS_FAIL, 3'd0, 1'b0));
        script.push_back(req_row(OP_ADD, 8'h04, 8'h00, 16'd0));
        script.push_back(set_row(CFG_MANAGER_ID, 16'd0));
        script.push_back(chk_row(OP_LOOKUP, 8'd0, 16'd0, STATUS_FAIL, 3'd0, 1'b0));
        script.push_back(req_row(OP_ADD, 8'h05, 8'h0F, 16'd1));
        script.push_back(req_row(OP_REMOVE, 8'h7F, 8'hF0, 16'd0));
        script.push_back(req_row(OP_LOOKUP, 8'h7F, 8'h00, 16'd0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        prev_set = 1'b0;
        foreach (script[i]) begin
            if (script[i].kind == ROW_SET) begin
                if (!prev_set)
                    wait_idle();
                write_register(script[i].reg_idx, script[i].reg_val);
            end else begin
                offer(script[i].op, script[i].id, script[i].atype, script[i].need,
                      script[i].fixed, script[i].reply);
            end
            prev_set = (script[i].kind == ROW_SET);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            for (int k = 0; k < MAX_AREAS; k++) begin
                if (k == 0) begin
                    case (p)
                        2: val = 16'd0;
                        3: val = 16'd255;
                        default: val = (p % 2 == 0) ? SIZE_W'($urandom_range(1, 20))
                                                    : SIZE_W'($urandom_range(1, 255));
                    endcase
                    write_register(CFG_MANAGER_ID, val);
                end else begin
                    case (p)
                        1: val = 16'hFFFF;
                        2: val = 16'd0;
                        default:
                            case ($urandom_range(3))
                                0: val = 16'd0;
                                1: val = 16'hFFFF;
                                2: val = SIZE_W'($urandom_range(1, 64));
                                default: val = SIZE_W'($urandom_range(65535));
                            endcase
                    endcase
                    write_register(cap_reg(k), val);
                end
            end

            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 69; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            // The block fills up and must stall its input while results back up.
            if (p == 4)
                hold_req = 1'b1;

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if ($urandom_range(99) < 85) begin
                    roll = $urandom_range(99);
                    op = (roll < 45) ? OP_ADD : (roll < 70) ? OP_REMOVE : OP_LOOKUP;
                    id = ($urandom_range(19) == 0) ? mgr_id
                                                   : ID_W'($urandom_range(1, 15));
                    if ($urandom_range(1)) begin
                        pick = AREA_IDX_W'($urandom_range(1, MAX_AREAS - 1));
                        need = area_cap[pick] - SIZE_W'($urandom_range(0, 1));
                    end else begin
                        need = SIZE_W'($urandom_range(0, 200));
                    end
                end else begin
                    op   = 2'($urandom_range(3));
                    id   = ID_W'($urandom_range(255));
                    need = SIZE_W'($urandom_range(65535));
                end
                offer(op, id, TYPE_W'($urandom_range(255)), need, 1'b0, '0);
            end
        end

        send_idle_pct = 0;
        stall_pct = 0;
        wait_idle();

        if (fail_count == 0 && pending_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bfa_pkg.sv
rtl/bfa_cmp_unit.sv
rtl/best_fit_area_allocator.sv
bench/tb.sv
